// ===== sv/setu_pkg.sv =====
// Shared types, constants and register codes for the Sobel edge thinning unit.
// No dependencies; every other file imports this package.
`default_nettype none

package setu_pkg;

    localparam int COL_W      = 10;             // out_col width, sets the line length
    localparam int MAX_WIDTH  = 1 << COL_W;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int THR_W      = 22;
    localparam int ROW_W      = 13;             // holds height + 2 during the drain
    localparam int OROW_W     = 12;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 10;
    localparam int MAG_W      = 2 * GRAD_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST   = 11'd640;
    localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST  = 12'd480;
    localparam logic [THR_W-1:0]    MAG_THRESHOLD_RST = 22'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_MAG_THRESHOLD = 2'd2
    } setu_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } setu_op_t;

    // one raster step handed from the front to the back
    typedef struct packed {
        logic [PIX_W-1:0]  pix;       // zero during the drain
        logic [COL_W-1:0]  col;
        logic              row0;      // row == 0
        logic              row1;      // row <= 1
        logic              col0;      // col == 0
        logic              col1;      // col == 1
        logic              emit;
        logic              interior;
        logic              fend;
        logic [COL_W-1:0]  ocol;
        logic [OROW_W-1:0] orow;
    } setu_tick_t;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } setu_col_t;

    typedef struct packed {
        logic [GRAD_W-1:0] ah;
        logic [GRAD_W-1:0] av;
    } setu_grad_t;

    typedef struct packed {
        setu_grad_t hi;               // previous row
        setu_grad_t lo;               // two rows back
    } setu_gpair_t;

endpackage

`default_nettype wire

// ===== sv/setu_if.sv =====
// Stream interfaces of the Sobel edge thinning unit: pixel input and edge result.
// Depends on setu_pkg.
`default_nettype none

interface setu_pixel_if
    import setu_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             op;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, op, pixel, input ready);
    modport sink   (input valid, op, pixel, output ready);
endinterface

interface setu_result_if
    import setu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              edge_res;
    logic [COL_W-1:0]  out_col;
    logic [OROW_W-1:0] out_row;
    logic              frame_end;

    modport source (output valid, edge_res, out_col, out_row, frame_end, input ready);
    modport sink   (input valid, edge_res, out_col, out_row, frame_end, output ready);
endinterface

`default_nettype wire

// ===== sv/setu_front.sv =====
// Front end: raster position counters, flush handling and result classification.
// Depends on setu_pkg and setu_if.
`default_nettype none

module setu_front
    import setu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    setu_pixel_if.sink               pixels,
    input  wire logic [WIDTH_W-1:0]  frame_width,
    input  wire logic [HEIGHT_W-1:0] frame_height,
    input  wire logic                q_ready,
    output logic                     q_push,
    output setu_tick_t               q_tick
);

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [WIDTH_W-1:0]  w_eff, w_m1, c_inc;
    logic [HEIGHT_W-1:0] h_eff, h_m1;
    logic [ROW_W-1:0]    h_ext, end_row, r, orow_full;
    logic [COL_W-1:0]    col_n, c, ocol;
    logic [OROW_W-1:0]   orow;
    logic                accept, pix_row, drop, emit, fend, interior;

    always_comb
    begin
        w_eff = frame_width;
        if (w_eff < WIDTH_W'(3))
            w_eff = WIDTH_W'(3);
        if (w_eff > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        h_eff = frame_height;
        if (h_eff < HEIGHT_W'(3))
            h_eff = HEIGHT_W'(3);
    end

    assign w_m1    = w_eff - WIDTH_W'(1);
    assign h_m1    = h_eff - HEIGHT_W'(1);
    assign h_ext   = {1'b0, h_eff};
    assign end_row = h_ext + ROW_W'(2);

    always_comb
    begin
        col_n = ({1'b0, col_reg} >= w_eff) ? '0 : col_reg;
        // past the end of the drain: restart the frame
        if (row_reg > end_row || (row_reg == end_row && col_n != '0))
        begin
            r = '0;
            c = '0;
        end
        else
        begin
            r = row_reg;
            c = col_n;
        end
    end

    assign pix_row   = r < h_ext;
    assign drop      = pix_row && (pixels.op == OP_FLUSH);
    assign emit      = !(r < ROW_W'(2) || (r == ROW_W'(2) && c == '0));
    assign ocol      = (c != '0) ? c - COL_W'(1) : w_m1[COL_W-1:0];
    assign orow_full = (c != '0) ? r - ROW_W'(2) : r - ROW_W'(3);
    assign orow      = orow_full[OROW_W-1:0];
    assign fend      = (orow == h_m1) && (ocol == w_m1[COL_W-1:0]);
    assign interior  = (orow != '0) && (ocol != '0) && (orow < h_m1)
                       && (ocol < w_m1[COL_W-1:0]);
    assign c_inc     = {1'b0, c} + WIDTH_W'(1);

    always_comb
    begin
        row_next = r;
        col_next = c;
        if (!drop)
        begin
            if (emit && fend)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (c_inc >= w_eff)
            begin
                col_next = '0;
                row_next = r + ROW_W'(1);
            end
            else
            begin
                col_next = c_inc[COL_W-1:0];
            end
        end
    end

    assign pixels.ready = q_ready;
    assign accept       = pixels.valid && q_ready;
    assign q_push       = accept && !drop;

    always_comb
    begin
        q_tick.pix      = pix_row ? pixels.pixel : '0;
        q_tick.col      = c;
        q_tick.row0     = (r == '0);
        q_tick.row1     = (r <= ROW_W'(1));
        q_tick.col0     = (c == '0);
        q_tick.col1     = (c == COL_W'(1));
        q_tick.emit     = emit;
        q_tick.interior = interior;
        q_tick.fend     = fend;
        q_tick.ocol     = ocol;
        q_tick.orow     = orow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/setu_queue.sv =====
// Short FIFO between the front end and the filter pipeline.
// Depends on setu_pkg.
`default_nettype none

module setu_queue
    import setu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire setu_tick_t  push_data,
    output logic             push_ready,
    output logic             pop_valid,
    output setu_tick_t       pop_data,
    input  wire logic        pop
);

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    setu_tick_t        slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== sv/setu_back.sv =====
// Filter pipeline: pixel line store and window, Sobel gradients, gradient
// line store, magnitude and non-maximum test, output register. Depends on setu_pkg, setu_if.
`default_nettype none

module setu_back
    import setu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire setu_tick_t       q_tick,
    output logic                  q_pop,
    input  wire logic [THR_W-1:0] mag_threshold,
    setu_result_if.source         results
);

    // column-indexed line stores: two older rows per entry
    logic [2*PIX_W-1:0] pmem [MAX_WIDTH];
    setu_gpair_t        gmem [MAX_WIDTH];

    logic               en;
    logic               a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, out_valid_reg;
    setu_tick_t         a_tick_reg, b_tick_reg, c_tick_reg, d_tick_reg;
    logic [2*PIX_W-1:0] prd_reg;
    setu_col_t          win0_reg, win1_reg, win2_reg;
    setu_col_t          a_col, rcol, lcol;
    setu_grad_t         b_grad, c_grad_reg, xs1_reg, xs2_reg, ys1_reg;
    setu_gpair_t        grd_reg;
    logic [2*GRAD_W-1:0] sq_h, sq_v;
    logic [MAG_W-1:0]   c_mag, d_mag_reg;
    logic               c_hmax, c_vmax, d_hmax_reg, d_vmax_reg, d_is_edge;
    logic               edge_res_reg, frame_end_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [OROW_W-1:0]  out_row_reg;

    function automatic logic [GRAD_W-1:0] tap_sum(input logic [PIX_W-1:0] x,
                                                  input logic [PIX_W-1:0] y,
                                                  input logic [PIX_W-1:0] z);
        tap_sum = {2'b00, x} + {1'b0, y, 1'b0} + {2'b00, z};
    endfunction

    function automatic logic [GRAD_W-1:0] abs_diff(input logic [GRAD_W-1:0] x,
                                                   input logic [GRAD_W-1:0] y);
        abs_diff = (x >= y) ? x - y : y - x;
    endfunction

    assign en    = !out_valid_reg || results.ready;
    assign q_pop = en && q_valid;

    // stage A: new column vector, rows above masked at the frame top
    always_comb
    begin
        a_col.bot = a_tick_reg.pix;
        a_col.mid = a_tick_reg.row0 ? '0 : prd_reg[2*PIX_W-1:PIX_W];
        a_col.top = a_tick_reg.row1 ? '0 : prd_reg[PIX_W-1:0];
    end

    // stage B: 3x3 window, side columns masked at the frame edges
    always_comb
    begin
        rcol      = b_tick_reg.col0 ? '0 : win0_reg;
        lcol      = b_tick_reg.col1 ? '0 : win2_reg;
        b_grad.av = abs_diff(tap_sum(rcol.top, rcol.mid, rcol.bot),
                             tap_sum(lcol.top, lcol.mid, lcol.bot));
        b_grad.ah = abs_diff(tap_sum(lcol.bot, win1_reg.bot, rcol.bot),
                             tap_sum(lcol.top, win1_reg.top, rcol.top));
    end

    // stage C: center is xs1; up ys1, down the fresh gradient, left xs2, right grd.hi
    assign sq_h   = xs1_reg.ah * xs1_reg.ah;
    assign sq_v   = xs1_reg.av * xs1_reg.av;
    assign c_mag  = {1'b0, sq_h} + {1'b0, sq_v};
    assign c_hmax = (xs1_reg.ah > xs1_reg.av) && (xs1_reg.ah > ys1_reg.ah)
                    && (xs1_reg.ah > c_grad_reg.ah);
    assign c_vmax = (xs1_reg.av > xs1_reg.ah) && (xs1_reg.av > xs2_reg.av)
                    && (xs1_reg.av > grd_reg.hi.av);

    // stage D
    assign d_is_edge = d_tick_reg.interior && ({1'b0, d_mag_reg} > mag_threshold)
                       && (d_hmax_reg || d_vmax_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= q_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg && d_tick_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_tick_reg <= q_tick;
            prd_reg    <= pmem[q_tick.col];
        end
        if (en && a_valid_reg)
        begin
            pmem[a_tick_reg.col] <= {a_tick_reg.pix, prd_reg[2*PIX_W-1:PIX_W]};
            win0_reg   <= a_col;
            win1_reg   <= win0_reg;
            win2_reg   <= win1_reg;
            b_tick_reg <= a_tick_reg;
        end
        if (en && b_valid_reg)
        begin
            c_grad_reg <= b_grad;
            c_tick_reg <= b_tick_reg;
            grd_reg    <= gmem[b_tick_reg.col];
        end
        if (en && c_valid_reg)
        begin
            gmem[c_tick_reg.ocol] <= {c_grad_reg, xs1_reg};
            xs1_reg    <= grd_reg.hi;
            xs2_reg    <= xs1_reg;
            ys1_reg    <= grd_reg.lo;
            d_tick_reg <= c_tick_reg;
            d_mag_reg  <= c_mag;
            d_hmax_reg <= c_hmax;
            d_vmax_reg <= c_vmax;
        end
        if (en && d_valid_reg && d_tick_reg.emit)
        begin
            edge_res_reg  <= d_is_edge;
            out_col_reg   <= d_tick_reg.ocol;
            out_row_reg   <= d_tick_reg.orow;
            frame_end_reg <= d_tick_reg.fend;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.edge_res  = edge_res_reg;
    assign results.out_col   = out_col_reg;
    assign results.out_row   = out_row_reg;
    assign results.frame_end = frame_end_reg;

endmodule

`default_nettype wire

// ===== sv/sobel_edge_thinning_unit.sv =====
// Sobel edge thinning unit: one pixel per clock, sustained, when the result side keeps up.
// A result is offered in the output register once the transaction that causes it has passed
// through the queue and stages A to D; each result describes the pixel two rows and one column before that transaction.
// Throughput is one transaction per cycle while the result side keeps up: every stage advances
// together, and each column line store takes one read and one write per cycle.
// Reset clears counters, pipeline valids and the queue, and loads 640 x 480, threshold 1000.
// Depends on setu_pkg, setu_if, setu_front, setu_queue, setu_back.
`default_nettype none

module sobel_edge_thinning_unit
    import setu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    setu_pixel_if.sink                 pixels,
    setu_result_if.source              results,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [WIDTH_W-1:0]  frame_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic [THR_W-1:0]    mag_threshold_reg;
    logic                q_push, q_ready, q_valid, q_pop;
    setu_tick_t          push_tick, pop_tick;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FRAME_WIDTH_RST;
            frame_height_reg  <= FRAME_HEIGHT_RST;
            mag_threshold_reg <= MAG_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (setu_reg_t'(cfg_index))
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data[HEIGHT_W-1:0];
                REG_MAG_THRESHOLD: mag_threshold_reg <= cfg_data[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    setu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_tick       (push_tick)
    );

    setu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (push_tick),
        .push_ready (q_ready),
        .pop_valid  (q_valid),
        .pop_data   (pop_tick),
        .pop        (q_pop)
    );

    setu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_tick        (pop_tick),
        .q_pop         (q_pop),
        .mag_threshold (mag_threshold_reg),
        .results       (results)
    );

    // the last pixel of a frame is a corner, never an edge
    a_fend_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.frame_end |-> !results.edge_res)
        else $error("edge reported on the frame's last pixel");

    a_edge_not_top_left: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.edge_res |-> results.out_row != '0 && results.out_col != '0)
        else $error("edge reported on the top row or left column");

    a_fend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.frame_end
        |-> {1'b0, results.out_row} >= ROW_W'(2) && {1'b0, results.out_col} >= WIDTH_W'(2))
        else $error("frame end reported inside a minimum frame");

    a_queue_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_ready)
        else $error("transaction pushed into a full queue");

endmodule

`default_nettype wire

// ===== tb/tb_sobel_edge_thinning_unit.sv =====
// Testbench for the Sobel edge thinning unit: raster pixel streams in, edge results out.
// It predicts every result from its own pixel history and checks each output transaction.
// Depends on setu_pkg, setu_if and the unit's RTL.
`default_nettype none

module tb_sobel_edge_thinning_unit;
    import setu_pkg::*;

    localparam int HIST = 4 * MAX_WIDTH + 4;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic              edge_res;
        logic [COL_W-1:0]  col;
        logic [OROW_W-1:0] row;
        logic              fend;
    } edge_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    setu_pixel_if  pixels();
    setu_result_if results();

    sobel_edge_thinning_unit dut (
        .clk(clk), .rst_n(rst_n), .pixels(pixels.sink), .results(results.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // predictor state
    logic [PIX_W-1:0] pix_hist [HIST];
    int unsigned cur_col, cur_row;
    int unsigned reg_width, reg_height, reg_thr;
    edge_result_t edge_queue[$];

    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    function automatic int unsigned eff_width();
        if (reg_width < 3) return 3;
        if (reg_width > MAX_WIDTH) return MAX_WIDTH;
        return reg_width;
    endfunction

    function automatic int unsigned eff_height();
        return (reg_height < 3) ? 3 : reg_height;
    endfunction

    function automatic int pix_val(int r, int c, int w, int h);
        if (r < 0 || c < 0 || r >= h || c >= w) return 0;
        return pix_hist[(r * w + c) % HIST];
    endfunction

    function automatic void sobel_pair(int r, int c, int w, int h,
                                       output int ah, output int av);
        int rt, lf, bt, tp;
        rt = pix_val(r-1, c+1, w, h) + 2*pix_val(r, c+1, w, h) + pix_val(r+1, c+1, w, h);
        lf = pix_val(r-1, c-1, w, h) + 2*pix_val(r, c-1, w, h) + pix_val(r+1, c-1, w, h);
        bt = pix_val(r+1, c-1, w, h) + 2*pix_val(r+1, c, w, h) + pix_val(r+1, c+1, w, h);
        tp = pix_val(r-1, c-1, w, h) + 2*pix_val(r-1, c, w, h) + pix_val(r-1, c+1, w, h);
        av = (rt > lf) ? rt - lf : lf - rt;
        ah = (bt > tp) ? bt - tp : tp - bt;
    endfunction

    function automatic logic thin_edge(int r, int c, int w, int h);
        int ah, av, ahu, avu, ahd, avd, ahl, avl, ahr, avr;
        longint unsigned mag;
        if (r <= 0 || c <= 0 || r >= h - 1 || c >= w - 1) return 1'b0;
        sobel_pair(r, c, w, h, ah, av);
        mag = ah * ah + av * av;
        if (mag <= reg_thr) return 1'b0;
        sobel_pair(r-1, c, w, h, ahu, avu);
        sobel_pair(r+1, c, w, h, ahd, avd);
        sobel_pair(r, c-1, w, h, ahl, avl);
        sobel_pair(r, c+1, w, h, ahr, avr);
        return (ah > av && ah > ahu && ah > ahd) || (av > ah && av > avl && av > avr);
    endfunction

    function automatic void predict_pixel(setu_op_t op, logic [PIX_W-1:0] px);
        int unsigned w, h, orow, ocol;
        edge_result_t res;
        w = eff_width();
        h = eff_height();
        if (cur_col >= w) cur_col = 0;
        if (cur_row > h + 2 || (cur_row == h + 2 && cur_col > 0)) begin
            cur_row = 0;
            cur_col = 0;
        end
        if (cur_row < h) begin
            if (op == OP_FLUSH) return;
            pix_hist[(cur_row * w + cur_col) % HIST] = px;
        end
        if (cur_row < 2 || (cur_row == 2 && cur_col == 0)) begin
            cur_col++;
            if (cur_col >= w) begin
                cur_col = 0;
                cur_row++;
            end
            return;
        end
        if (cur_col >= 1) begin
            orow = cur_row - 2;
            ocol = cur_col - 1;
        end
        else begin
            orow = cur_row - 3;
            ocol = w - 1;
        end
        res.fend = (orow == h - 1 && ocol == w - 1);
        res.edge_res = thin_edge(orow, ocol, w, h);
        res.col = ocol[COL_W-1:0];
        res.row = orow[OROW_W-1:0];
        edge_queue.push_back(res);
        if (res.fend) begin
            cur_col = 0;
            cur_row = 0;
        end
        else begin
            cur_col++;
            if (cur_col >= w) begin
                cur_col = 0;
                cur_row++;
            end
        end
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sobel_edge_thinning_unit: mismatch");
            $finish;
        end
    end

    // result checker
    always @(posedge clk) begin
        edge_result_t got, want;
        if (rst_n && results.valid && results.ready) begin
            got = {results.edge_res, results.out_col, results.out_row, results.frame_end};
            if (edge_queue.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, got);
                errors++;
            end
            else begin
                want = edge_queue.pop_front();
                if (got !== want) begin
                    $display("%0t: expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        results.ready <= ($urandom_range(99) >= stall_pct);

    // valid stays high into the next transaction; drain_results drops it
    task automatic send_item(setu_op_t op, logic [PIX_W-1:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            pixels.valid <= 1'b0;
            @(negedge clk);
        end
        pixels.valid <= 1'b1;
        pixels.op <= op;
        pixels.pixel <= px;
        do @(posedge clk); while (!pixels.ready);
        predict_pixel(op, px);
        @(negedge clk);
    endtask

    task automatic drain_results();
        pixels.valid <= 1'b0;
        while (edge_queue.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(setu_reg_t idx, int unsigned value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:   reg_width = value & 11'h7ff;
            REG_FRAME_HEIGHT:  reg_height = value & 12'hfff;
            REG_MAG_THRESHOLD: reg_thr = value & 22'h3fffff;
            default: ;
        endcase
    endtask

    // one frame: pattern 0 random, 1 vertical stripes, 2 horizontal stripes, 3 extremes
    task automatic send_frame(int pattern, int junk_flushes);
        int unsigned w, h;
        logic [PIX_W-1:0] px;
        w = eff_width();
        h = eff_height();
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++) begin
                case (pattern)
                    1: px = (c % 4 < 2) ? 8'hff : 8'h00;
                    2: px = (r % 3 == 0) ? 8'hff : $urandom_range(20);
                    3: px = ((r + c) % 2) ? 8'hff : 8'h00;
                    default: px = $urandom_range(255);
                endcase
                if (junk_flushes > 0 && $urandom_range(15) == 0)
                    send_item(OP_FLUSH, $urandom_range(255));
                send_item(OP_PIXEL, px);
            end
        // drain, sometimes with pixel items acting as flushes
        for (int i = 0; i < 2 * w + 1; i++)
            send_item($urandom_range(3) == 0 ? OP_PIXEL : OP_FLUSH, $urandom_range(255));
    endtask

    task automatic test_directed();
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        write_reg(REG_MAG_THRESHOLD, 0);
        send_item(OP_FLUSH, 8'hff);          // ignored at frame start
        send_frame(3, 0);
        write_reg(REG_FRAME_WIDTH, 4);
        write_reg(REG_FRAME_HEIGHT, 4);
        send_frame(1, 1);
        // out-of-range registers clamp
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 0);
        write_reg(REG_MAG_THRESHOLD, 4194303);
        send_frame(3, 0);
    endtask

    task automatic test_random(int n_items);
        int sent;
        int unsigned w, h;
        sent = 0;
        while (sent < n_items) begin
            w = $urandom_range(3, 9);
            h = $urandom_range(3, 7);
            write_reg(REG_FRAME_WIDTH, w);
            write_reg(REG_FRAME_HEIGHT, h);
            write_reg(REG_MAG_THRESHOLD, $urandom_range(3) == 0 ? $urandom_range(4194303)
                                                             : $urandom_range(200000));
            send_frame($urandom_range(3), 1);
            sent += (w * h) + 2 * w + 1;
        end
    endtask

    task automatic test_wide();
        write_reg(REG_FRAME_WIDTH, 2047);    // clamps to the line length
        write_reg(REG_FRAME_HEIGHT, 4095);
        for (int i = 0; i < 20; i++) send_item(OP_PIXEL, $urandom_range(255));
        write_reg(REG_FRAME_WIDTH, 5);       // column past the new width restarts at 0
        write_reg(REG_FRAME_HEIGHT, 3);
        write_reg(REG_MAG_THRESHOLD, 1000);
        send_frame(0, 0);
        write_reg(REG_FRAME_HEIGHT, 6);
        for (int i = 0; i < 33; i++) send_item(OP_PIXEL, $urandom_range(255));
        write_reg(REG_FRAME_HEIGHT, 3);      // position past the end of the drain restarts
        send_frame(2, 0);
    endtask

    // threshold is still at its maximum here, so mixed-width history never shows
    task automatic test_mid_frame_change();
        write_reg(REG_FRAME_WIDTH, 8);
        write_reg(REG_FRAME_HEIGHT, 6);
        for (int i = 0; i < 30; i++) send_item(OP_PIXEL, $urandom_range(255));
        drain_results();
        write_reg(REG_FRAME_WIDTH, 5);
        // rows 3 to 5 remain, then the drain, so the next frame starts aligned
        for (int i = 0; i < 15; i++) send_item(OP_PIXEL, $urandom_range(255));
        for (int i = 0; i < 11; i++) send_item(OP_FLUSH, $urandom_range(255));
    endtask

    initial begin
        for (int i = 0; i < HIST; i++) pix_hist[i] = '0;
        cur_col = 0;
        cur_row = 0;
        reg_width = 640;
        reg_height = 480;
        reg_thr = 1000;
        pixels.valid = 1'b0;
        pixels.op = 1'b0;
        pixels.pixel = '0;
        results.ready = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_mid_frame_change();
        test_wide();
        send_idle_pct = 0;  stall_pct = 0;  test_random(100);
        send_idle_pct = 45; stall_pct = 0;  test_random(100);
        drain_results();    // sender holds until every result is in
        send_idle_pct = 0;  stall_pct = 45; test_random(100);
        send_idle_pct = 19; stall_pct = 19; test_random(100);
        drain_results();
        repeat (20) @(negedge clk);
        if (errors == 0 && edge_queue.size() == 0)
            $display("sobel_edge_thinning_unit: match");
        else
            $display("sobel_edge_thinning_unit: mismatch");
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
sv/setu_pkg.sv
sv/setu_if.sv
sv/setu_front.sv
sv/setu_queue.sv
sv/setu_back.sv
sv/sobel_edge_thinning_unit.sv
tb/tb_sobel_edge_thinning_unit.sv
